// ===== design/rcwe_pkg.sv =====
package rcwe_pkg;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_QUEUED     = 3'd0,
        EV_NEW_ACK    = 3'd1,
        EV_DUP_ACK    = 3'd2,
        EV_FAST_RETX  = 3'd3,
        EV_TIMEOUT    = 3'd4,
        EV_QUEUE_FULL = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        REG_MSS       = 2'd0,
        REG_INIT_WIN  = 2'd1,
        REG_INIT_THR  = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SQUARE,
        ST_DIV,
        ST_GROW,
        ST_POP_READ,
        ST_POP_TEST,
        ST_ROOM,
        ST_OUT
    } state_t;

    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
    localparam logic [1:0]  DUP_LIMIT  = 2'd3;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctrl_t;

endpackage

// ===== design/rcwe_divider.sv =====
module rcwe_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output rcwe_pkg::div_ctrl_t ctrl,
    output logic [NUM_W-1:0] quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
            if (trial >= {1'b0, denom})
            begin
                r_next = trial - {1'b0, denom};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign ctrl.done  = done_reg;
    assign quot       = q_reg;
endmodule

// ===== design/reno_congestion_window_engine.sv =====
// Reno congestion window engine.
// Input channel: in_valid/in_stall carry one item (cmd, seg_len, ack_number).
// Output channel: out_valid/out_stall carry exactly one result item per input.
// The block holds one item at a time: in_stall is high from acceptance until
// the result has been loaded into the output register.
// Sequence: send, timeout, duplicate ack and the idle command pass through
// decode, room and output states; the next item is taken after the output state.
// A new ack adds a read and a test state per popped segment, and the pop loop
// ends on a read that finds the queue empty or on a test that stops it.
// Congestion avoidance adds a square step, a serial divide of 2*FRAC_BITS+32
// quotient bits (one a cycle) and a grow step, all before any pop.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge and
// must only be issued while the block is idle; writing initial_window or
// initial_threshold reloads the live window or threshold.
// Reset clears sequence numbers to one, the queue to empty, recovery off and
// loads the window and threshold from the reset register values.
// If the receiver stalls, the result holds in the output register and the
// next item is taken meanwhile; its result waits until the register frees.
module reno_congestion_window_engine #(
    parameter int QUEUE_DEPTH = 64,
    parameter int FRAC_BITS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] seg_len,
    input  logic [31:0] ack_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic        retransmit,
    output logic [31:0] retx_seq,
    output logic [15:0] retx_len,
    output logic        restart_timer,
    output logic [31:0] window_bytes,
    output logic [31:0] threshold_bytes,
    output logic [31:0] base_seq,
    output logic [31:0] next_seq,
    output logic [31:0] room,
    output logic        in_recovery,
    output logic [6:0]  outstanding
);
    localparam int WW   = 32 + FRAC_BITS;
    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int NW   = 32 + 2 * FRAC_BITS;
    localparam logic [WW-1:0] WMAX = {WW{1'b1}};

    rcwe_pkg::state_t state_reg, state_next;

    logic [15:0]   mss_reg;
    logic [31:0]   base_reg, next_reg;
    logic [WW-1:0] win_reg, thr_reg;
    logic [1:0]    dup_reg;
    logic          rec_reg;
    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;

    logic [1:0]    cmd_reg;
    logic [15:0]   len_reg;
    logic [31:0]   ack_reg;
    logic [2:0]    ev_reg;
    logic          retx_reg, rst_tmr_reg;
    logic [31:0]   sq_reg;
    logic [31:0]   rd_seq_reg;
    logic [15:0]   rd_len_reg;
    logic [WW-1:0] inc_reg;
    logic          inc_ok_reg;

    logic [47:0]   store [QUEUE_DEPTH];
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic          obuf_full_reg;
    logic          div_start;
    rcwe_pkg::div_ctrl_t div_ctrl;
    logic [NW-1:0] div_quot;

    logic [WW:0]   add_a, add_b, add_s;
    logic [WW-1:0] add_sat;
    logic [32:0]   top;
    logic [32:0]   room_w;
    logic [FW:0]   slot_sum;

    // shared saturating adder
    assign add_s   = add_a + add_b;
    assign add_sat = add_s[WW] ? WMAX : add_s[WW-1:0];

    assign slot_sum = {1'b0, FW'(head_reg)} + {1'b0, fill_reg};
    assign wr_addr  = (slot_sum >= (FW+1)'(QUEUE_DEPTH))
                      ? AW'(slot_sum - (FW+1)'(QUEUE_DEPTH)) : AW'(slot_sum);
    assign rd_addr  = head_reg;

    rcwe_divider #(.NUM_W(NW), .DEN_W(WW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({sq_reg, {(2*FRAC_BITS){1'b0}}}),
        .denom (win_reg),
        .ctrl  (div_ctrl),
        .quot  (div_quot)
    );

    wire dup_ack = ((ack_reg - base_reg) >= rcwe_pkg::HALF_RANGE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcwe_pkg::ST_IDLE:
                if (in_valid) state_next = rcwe_pkg::ST_DECODE;
            rcwe_pkg::ST_DECODE:
                if (cmd_reg == rcwe_pkg::CMD_ACK && !dup_ack && !rec_reg
                    && win_reg >= thr_reg)
                    state_next = rcwe_pkg::ST_SQUARE;
                else if (cmd_reg == rcwe_pkg::CMD_ACK && !dup_ack)
                    state_next = rcwe_pkg::ST_POP_READ;
                else
                    state_next = rcwe_pkg::ST_ROOM;
            rcwe_pkg::ST_SQUARE:
                state_next = rcwe_pkg::ST_DIV;
            rcwe_pkg::ST_DIV:
                if (div_ctrl.done) state_next = rcwe_pkg::ST_GROW;
            rcwe_pkg::ST_GROW:
                state_next = rcwe_pkg::ST_POP_READ;
            rcwe_pkg::ST_POP_READ:
                state_next = (fill_reg == '0) ? rcwe_pkg::ST_ROOM
                                              : rcwe_pkg::ST_POP_TEST;
            rcwe_pkg::ST_POP_TEST:
                state_next = ((ack_reg - rd_seq_reg) < rcwe_pkg::HALF_RANGE)
                             ? rcwe_pkg::ST_POP_READ : rcwe_pkg::ST_ROOM;
            rcwe_pkg::ST_ROOM:
                state_next = rcwe_pkg::ST_OUT;
            rcwe_pkg::ST_OUT:
                if (!obuf_full_reg || !out_stall) state_next = rcwe_pkg::ST_IDLE;
            default:
                state_next = rcwe_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall  = (state_reg != rcwe_pkg::ST_IDLE);
        div_start = (state_reg == rcwe_pkg::ST_SQUARE);
        wr_en     = (state_reg == rcwe_pkg::ST_DECODE) && (cmd_reg == rcwe_pkg::CMD_SEND)
                    && (fill_reg < FW'(QUEUE_DEPTH));
        add_a     = {1'b0, win_reg};
        add_b     = {1'b0, WW'({mss_reg, {FRAC_BITS{1'b0}}})};
        case (state_reg)
            rcwe_pkg::ST_DECODE:
            begin
                if (dup_ack && !rec_reg)
                begin
                    add_a = {2'b0, win_reg[WW-1:1]};
                    add_b = {1'b0, WW'({mss_reg, {FRAC_BITS{1'b0}}})}
                          + {1'b0, WW'({mss_reg, {(FRAC_BITS+1){1'b0}}})};
                end
            end
            rcwe_pkg::ST_GROW:
                add_b = {1'b0, inc_reg};
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr] <= {next_reg, len_reg};
        {rd_seq_reg, rd_len_reg} <= store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcwe_pkg::ST_IDLE;
            mss_reg       <= 16'd500;
            base_reg      <= 32'd1;
            next_reg      <= 32'd1;
            win_reg       <= WW'({32'd500, {FRAC_BITS{1'b0}}});
            thr_reg       <= WW'({32'd65535, {FRAC_BITS{1'b0}}});
            dup_reg       <= '0;
            rec_reg       <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            obuf_full_reg <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // load a new result, or drop the one just taken
            if (state_reg == rcwe_pkg::ST_OUT && (!obuf_full_reg || !out_stall))
            begin
                out_valid     <= 1'b1;
                obuf_full_reg <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid     <= 1'b0;
                obuf_full_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    rcwe_pkg::REG_MSS:
                        mss_reg <= cfg_data[15:0];
                    rcwe_pkg::REG_INIT_WIN:
                        win_reg <= WW'({cfg_data, {FRAC_BITS{1'b0}}});
                    rcwe_pkg::REG_INIT_THR:
                        thr_reg <= WW'({cfg_data, {FRAC_BITS{1'b0}}});
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                rcwe_pkg::ST_DECODE:
                    case (cmd_reg)
                        rcwe_pkg::CMD_SEND:
                            if (fill_reg < FW'(QUEUE_DEPTH))
                            begin
                                fill_reg <= fill_reg + 1'b1;
                                next_reg <= next_reg + {16'd0, len_reg};
                            end
                        rcwe_pkg::CMD_ACK:
                            if (dup_ack)
                            begin
                                if (dup_reg >= 2'd2)
                                begin
                                    dup_reg <= rcwe_pkg::DUP_LIMIT;
                                    if (rec_reg)
                                        win_reg <= add_sat;
                                    else
                                    begin
                                        thr_reg <= {1'b0, win_reg[WW-1:1]};
                                        win_reg <= add_sat;
                                        rec_reg <= 1'b1;
                                    end
                                end
                                else
                                    dup_reg <= dup_reg + 1'b1;
                            end
                            else
                            begin
                                dup_reg <= '0;
                                if (rec_reg)
                                begin
                                    win_reg <= thr_reg;
                                    rec_reg <= 1'b0;
                                end
                                else if (win_reg < thr_reg)
                                    win_reg <= add_sat;
                            end
                        rcwe_pkg::CMD_TIMEOUT:
                        begin
                            rec_reg <= 1'b0;
                            dup_reg <= '0;
                            thr_reg <= {1'b0, win_reg[WW-1:1]};
                            win_reg <= WW'({mss_reg, {FRAC_BITS{1'b0}}});
                        end
                        default:
                        begin
                        end
                    endcase
                rcwe_pkg::ST_GROW:
                    win_reg <= add_sat;
                rcwe_pkg::ST_POP_TEST:
                    if ((ack_reg - rd_seq_reg) < rcwe_pkg::HALF_RANGE)
                    begin
                        base_reg <= rd_seq_reg + {16'd0, rd_len_reg};
                        head_reg <= (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                    : head_reg + 1'b1;
                        fill_reg <= fill_reg - 1'b1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    assign top    = {1'b0, base_reg} + {1'b0, win_reg[WW-1:FRAC_BITS]};
    assign room_w = (top > {1'b0, next_reg}) ? top - {1'b0, next_reg} : '0;

    // per-item working registers and result register
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rcwe_pkg::ST_IDLE:
                if (in_valid)
                begin
                    cmd_reg <= cmd;
                    len_reg <= seg_len;
                    ack_reg <= ack_number;
                end
            rcwe_pkg::ST_DECODE:
            begin
                retx_reg    <= 1'b0;
                rst_tmr_reg <= 1'b0;
                ev_reg      <= rcwe_pkg::EV_QUEUED;
                case (cmd_reg)
                    rcwe_pkg::CMD_SEND:
                        if (fill_reg >= FW'(QUEUE_DEPTH))
                            ev_reg <= rcwe_pkg::EV_QUEUE_FULL;
                        else
                            rst_tmr_reg <= (fill_reg == '0);
                    rcwe_pkg::CMD_ACK:
                        if (dup_ack)
                        begin
                            ev_reg <= rcwe_pkg::EV_DUP_ACK;
                            if (dup_reg >= 2'd2 && !rec_reg)
                            begin
                                ev_reg   <= rcwe_pkg::EV_FAST_RETX;
                                retx_reg <= (fill_reg != '0);
                            end
                        end
                        else
                        begin
                            ev_reg      <= rcwe_pkg::EV_NEW_ACK;
                            rst_tmr_reg <= 1'b1;
                        end
                    rcwe_pkg::CMD_TIMEOUT:
                    begin
                        ev_reg      <= rcwe_pkg::EV_TIMEOUT;
                        retx_reg    <= (fill_reg != '0);
                        rst_tmr_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            rcwe_pkg::ST_SQUARE:
                inc_ok_reg <= (win_reg != '0);
            rcwe_pkg::ST_DIV:
                if (div_ctrl.done)
                    inc_reg <= (!inc_ok_reg || div_quot[NW-1:WW] != '0)
                               ? WMAX : div_quot[WW-1:0];
            rcwe_pkg::ST_ROOM:
            begin
            end
            rcwe_pkg::ST_OUT:
                if (!obuf_full_reg || !out_stall)
                begin
                    event_res       <= ev_reg;
                    retransmit      <= retx_reg;
                    retx_seq        <= retx_reg ? rd_seq_reg : 32'd0;
                    retx_len        <= retx_reg ? rd_len_reg : 16'd0;
                    restart_timer   <= rst_tmr_reg;
                    window_bytes    <= win_reg[WW-1:FRAC_BITS];
                    threshold_bytes <= thr_reg[WW-1:FRAC_BITS];
                    base_seq        <= base_reg;
                    next_seq        <= next_reg;
                    room            <= room_w[32] ? 32'hFFFF_FFFF : room_w[31:0];
                    in_recovery     <= rec_reg;
                    outstanding     <= 7'(fill_reg);
                end
            default:
            begin
            end
        endcase
        sq_reg <= {16'd0, mss_reg} * {16'd0, mss_reg};
    end
endmodule

// ===== bench/reno_window_checker.sv =====
module reno_window_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] seg_len,
    input  logic [31:0] ack_number,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  event_res,
    input  logic        retransmit,
    input  logic [31:0] retx_seq,
    input  logic [15:0] retx_len,
    input  logic        restart_timer,
    input  logic [31:0] window_bytes,
    input  logic [31:0] threshold_bytes,
    input  logic [31:0] base_seq,
    input  logic [31:0] next_seq,
    input  logic [31:0] room,
    input  logic        in_recovery,
    input  logic [6:0]  outstanding,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH     = 64;
    localparam int          FRAC      = 8;
    localparam int          EXP_SLOTS = 8;
    localparam logic [63:0] WIN_MAX   = (64'd1 << (32 + FRAC)) - 64'd1;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  ev;
        logic        retx;
        logic [31:0] rseq;
        logic [15:0] rlen;
        logic        restart;
        logic [31:0] win;
        logic [31:0] thr;
        logic [31:0] base;
        logic [31:0] nxt;
        logic [31:0] rm;
        logic        recov;
        logic [6:0]  fill;
    } window_result_t;

    logic [15:0] mss_r;
    logic [31:0] base_r, next_r;
    logic [63:0] cwnd_fx, ssthresh_fx;
    logic [1:0]  dups;
    logic        recovering;
    logic [31:0] seg_seq [DEPTH];
    logic [15:0] seg_sz  [DEPTH];
    int          head, fill;
    window_result_t expected_results [EXP_SLOTS];
    int          exp_rd, exp_wr, exp_count;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        if (a > WIN_MAX) a = WIN_MAX;
        if (b > WIN_MAX) b = WIN_MAX;
        s = a + b;
        return (s > WIN_MAX) ? WIN_MAX : s;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
        mismatches++;
    endtask

    task automatic predict_step(rcwe_pkg::cmd_t op, logic [15:0] len, logic [31:0] ack);
        window_result_t r;
        logic [63:0] mss_fx, num, inc, top, rm;
        int slot;
        r = '0;
        mss_fx = 64'(mss_r) << FRAC;
        r.ev = rcwe_pkg::EV_QUEUED;
        case (op)
            rcwe_pkg::CMD_SEND:
                if (fill >= DEPTH) r.ev = rcwe_pkg::EV_QUEUE_FULL;
                else
                begin
                    slot = (head + fill) % DEPTH;
                    seg_seq[slot] = next_r;
                    seg_sz[slot] = len;
                    r.restart = (fill == 0);
                    fill++;
                    next_r += 32'(len);
                end
            rcwe_pkg::CMD_ACK:
                if ((ack - base_r) >= rcwe_pkg::HALF_RANGE)
                begin
                    r.ev = rcwe_pkg::EV_DUP_ACK;
                    if (dups < rcwe_pkg::DUP_LIMIT) dups++;
                    if (dups >= rcwe_pkg::DUP_LIMIT)
                    begin
                        if (recovering) cwnd_fx = sat_add(cwnd_fx, mss_fx);
                        else
                        begin
                            ssthresh_fx = cwnd_fx >> 1;
                            cwnd_fx = sat_add(ssthresh_fx, 3 * mss_fx);
                            recovering = 1'b1;
                            r.ev = rcwe_pkg::EV_FAST_RETX;
                            r.retx = (fill != 0);
                        end
                    end
                end
                else
                begin
                    r.ev = rcwe_pkg::EV_NEW_ACK;
                    dups = '0;
                    if (recovering)
                    begin
                        cwnd_fx = ssthresh_fx;
                        recovering = 1'b0;
                    end
                    else if (cwnd_fx >= ssthresh_fx)
                    begin
                        num = (64'(mss_r) * 64'(mss_r)) << (2 * FRAC);
                        inc = (cwnd_fx == 0) ? WIN_MAX : num / cwnd_fx;
                        cwnd_fx = sat_add(cwnd_fx, inc);
                    end
                    else cwnd_fx = sat_add(cwnd_fx, mss_fx);
                    while (fill != 0 && (ack - seg_seq[head]) < rcwe_pkg::HALF_RANGE)
                    begin
                        base_r = seg_seq[head] + 32'(seg_sz[head]);
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                    r.restart = 1'b1;
                end
            rcwe_pkg::CMD_TIMEOUT:
            begin
                r.ev = rcwe_pkg::EV_TIMEOUT;
                r.retx = (fill != 0);
                r.restart = 1'b1;
                recovering = 1'b0;
                dups = '0;
                ssthresh_fx = cwnd_fx >> 1;
                cwnd_fx = mss_fx;
            end
            default: ;
        endcase
        top = 64'(base_r) + (cwnd_fx >> FRAC);
        rm = (top > 64'(next_r)) ? top - 64'(next_r) : 64'd0;
        if (rm > 64'(ALL_ONES)) rm = 64'(ALL_ONES);
        if (r.retx)
        begin
            r.rseq = seg_seq[head];
            r.rlen = seg_sz[head];
        end
        r.win = 32'(cwnd_fx >> FRAC);
        r.thr = 32'(ssthresh_fx >> FRAC);
        r.base = base_r;
        r.nxt = next_r;
        r.rm = 32'(rm);
        r.recov = recovering;
        r.fill = 7'(fill);
        expected_results[exp_wr] = r;
        exp_wr = (exp_wr + 1) % EXP_SLOTS;
        exp_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t w;
        if (!rst_n)
        begin
            mss_r = 16'd500;
            base_r = 32'd1;
            next_r = 32'd1;
            cwnd_fx = 64'd500 << FRAC;
            ssthresh_fx = 64'd65535 << FRAC;
            dups = '0;
            recovering = 1'b0;
            head = 0;
            fill = 0;
            exp_rd = 0;
            exp_wr = 0;
            exp_count = 0;
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (exp_count == 0)
                    report("unexpected result item", 32'(event_res), 32'd0);
                else
                begin
                    w = expected_results[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_SLOTS;
                    exp_count--;
                    if (event_res != w.ev) report("event_res", 32'(event_res), 32'(w.ev));
                    if (retransmit != w.retx) report("retransmit", 32'(retransmit), 32'(w.retx));
                    if (retx_seq != w.rseq) report("retx_seq", retx_seq, w.rseq);
                    if (retx_len != w.rlen) report("retx_len", 32'(retx_len), 32'(w.rlen));
                    if (restart_timer != w.restart)
                        report("restart_timer", 32'(restart_timer), 32'(w.restart));
                    if (window_bytes != w.win) report("window_bytes", window_bytes, w.win);
                    if (threshold_bytes != w.thr) report("threshold_bytes", threshold_bytes, w.thr);
                    if (base_seq != w.base) report("base_seq", base_seq, w.base);
                    if (next_seq != w.nxt) report("next_seq", next_seq, w.nxt);
                    if (room != w.rm) report("room", room, w.rm);
                    if (in_recovery != w.recov) report("in_recovery", 32'(in_recovery), 32'(w.recov));
                    if (outstanding != w.fill) report("outstanding", 32'(outstanding), 32'(w.fill));
                end
            end
            if (cfg_we)
                case (rcwe_pkg::reg_index_t'(cfg_index))
                    rcwe_pkg::REG_MSS:      mss_r = cfg_data[15:0];
                    rcwe_pkg::REG_INIT_WIN: cwnd_fx = 64'(cfg_data) << FRAC;
                    rcwe_pkg::REG_INIT_THR: ssthresh_fx = 64'(cfg_data) << FRAC;
                    default: ;
                endcase
            if (in_valid && !in_stall)
                predict_step(rcwe_pkg::cmd_t'(cmd), seg_len, ack_number);
        end
        pending = exp_count;
    end

endmodule

// ===== bench/tb_reno_congestion_window_engine.sv =====
module tb_reno_congestion_window_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int         SEG_SLOTS = 64;

    logic        clk, rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid, in_stall;
    logic [1:0]  cmd;
    logic [15:0] seg_len;
    logic [31:0] ack_number;
    logic        out_valid, out_stall;
    logic [2:0]  event_res;
    logic        retransmit;
    logic [31:0] retx_seq;
    logic [15:0] retx_len;
    logic        restart_timer;
    logic [31:0] window_bytes, threshold_bytes, base_seq, next_seq, room;
    logic        in_recovery;
    logic [6:0]  outstanding;
    int          mismatches, pending;
    int          idle_pct, stall_pct;
    int          items_sent;

    // shadow of the unacknowledged queue, used to aim acks at real boundaries and to fill the queue
    logic [31:0] sent_seq [SEG_SLOTS];
    logic [15:0] sent_len [SEG_SLOTS];
    int          sent_head, sent_count;
    logic [31:0] acked_base, seq_head;

    reno_congestion_window_engine u_top (.*);

    reno_window_checker u_checker (.*);

    always #1 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic push_item(rcwe_pkg::cmd_t op, logic [15:0] len, logic [31:0] ack);
        int slot;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        seg_len <= len;
        ack_number <= ack;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (op == rcwe_pkg::CMD_SEND && sent_count < SEG_SLOTS)
        begin
            slot = (sent_head + sent_count) % SEG_SLOTS;
            sent_seq[slot] = seq_head;
            sent_len[slot] = len;
            sent_count++;
            seq_head += 32'(len);
        end
        else if (op == rcwe_pkg::CMD_ACK && (ack - acked_base) < rcwe_pkg::HALF_RANGE)
            while (sent_count != 0 && (ack - sent_seq[sent_head]) < rcwe_pkg::HALF_RANGE)
            begin
                acked_base = sent_seq[sent_head] + 32'(sent_len[sent_head]);
                sent_head = (sent_head + 1) % SEG_SLOTS;
                sent_count--;
            end
        @(negedge clk);
    endtask

    task automatic random_item;
        int r, k, slot;
        r = $urandom_range(99);
        if (r < 4)
            // fill the queue and knock once more
            while (sent_count < SEG_SLOTS + 1)
            begin
                push_item(rcwe_pkg::CMD_SEND, 16'($urandom_range(1, 1460)), $urandom);
                if (sent_count == SEG_SLOTS)
                begin
                    push_item(rcwe_pkg::CMD_SEND, 16'($urandom), $urandom);
                    break;
                end
            end
        else if (r < 40)
            push_item(rcwe_pkg::CMD_SEND, ($urandom_range(9) == 0) ? 16'($urandom)
                                : 16'($urandom_range(0, 1460)), $urandom);
        else if (r < 74)
        begin
            if (sent_count == 0) push_item(rcwe_pkg::CMD_ACK, $urandom, acked_base);
            else
            begin
                k = $urandom_range(sent_count - 1);
                slot = (sent_head + k) % SEG_SLOTS;
                push_item(rcwe_pkg::CMD_ACK, $urandom, sent_seq[slot] + 32'(sent_len[slot]));
            end
        end
        else if (r < 88)
            push_item(rcwe_pkg::CMD_ACK, $urandom, acked_base - $urandom_range(1, 5000));
        else if (r < 94)
            push_item(rcwe_pkg::CMD_TIMEOUT, $urandom, $urandom);
        else if (r < 97)
            push_item(rcwe_pkg::CMD_ACK, $urandom, $urandom);
        else
            push_item(rcwe_pkg::CMD_NONE, $urandom, $urandom);
    endtask

    initial
    begin
        #2000000;
        $display("FAIL reno_congestion_window_engine");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rcwe_pkg::REG_MSS;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = rcwe_pkg::CMD_NONE;
        seg_len = '0;
        ack_number = '0;
        out_stall = 1'b0;
        idle_pct = 15;
        stall_pct = 57;
        items_sent = 0;
        sent_head = 0;
        sent_count = 0;
        acked_base = 32'd1;
        seq_head = 32'd1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty-queue timeout, idle command, edge lengths, Reno recovery
        push_item(rcwe_pkg::CMD_TIMEOUT, '0, '0);
        push_item(rcwe_pkg::CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF);
        push_item(rcwe_pkg::CMD_ACK, '0, 32'd1);
        push_item(rcwe_pkg::CMD_SEND, 16'hFFFF, '0);
        push_item(rcwe_pkg::CMD_SEND, 16'd0, '0);
        push_item(rcwe_pkg::CMD_SEND, 16'd100, '0);
        push_item(rcwe_pkg::CMD_SEND, 16'd1, '0);
        repeat (4) push_item(rcwe_pkg::CMD_ACK, '0, 32'd0);
        push_item(rcwe_pkg::CMD_ACK, '0, 32'd65536);
        repeat (3) push_item(rcwe_pkg::CMD_ACK, '0, acked_base - 32'd1);
        push_item(rcwe_pkg::CMD_TIMEOUT, '0, '0);
        push_item(rcwe_pkg::CMD_ACK, '0, acked_base + 32'd100);
        push_item(rcwe_pkg::CMD_ACK, '0, acked_base + 32'h7FFF_FFFF);
        push_item(rcwe_pkg::CMD_TIMEOUT, '0, '0);
        while (items_sent < 200) random_item();

        for (int phase = 1; phase < 4; phase++)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            drain();
            case (phase)
                1:
                begin
                    write_reg(rcwe_pkg::REG_MSS, 32'h0000_FFFF);
                    write_reg(rcwe_pkg::REG_INIT_WIN, 32'hFFFF_FFFF);
                    write_reg(rcwe_pkg::REG_INIT_THR, 32'd1);
                    write_reg(REG_SPARE, $urandom);
                end
                2:
                begin
                    idle_pct = 57;
                    stall_pct = 15;
                    write_reg(rcwe_pkg::REG_MSS, 32'd1);
                    write_reg(rcwe_pkg::REG_INIT_WIN, 32'd1);
                    write_reg(rcwe_pkg::REG_INIT_THR, 32'hFFFF_FFFF);
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    write_reg(rcwe_pkg::REG_MSS, $urandom_range(1, 1460));
                    write_reg(rcwe_pkg::REG_INIT_WIN, $urandom_range(1, 200000));
                    write_reg(rcwe_pkg::REG_INIT_THR, $urandom_range(1, 400000));
                end
            endcase
            while (items_sent < 200 * (phase + 1)) random_item();
        end

        in_valid <= 1'b0;
        @(negedge clk);
        drain();
        if (mismatches == 0)
            $display("PASS reno_congestion_window_engine");
        else
            $display("FAIL reno_congestion_window_engine");
        $finish;
    end

endmodule
